// ----- src/cci_pkg.sv -----
// shared widths, result codes and pipeline sideband types for the circle intersection block
package cci_pkg;

    localparam int CRD_W   = 16;                 // center coordinate
    localparam int RAD_IN_W = 15;                // radius
    localparam int DIF_W   = CRD_W + 1;          // center difference
    localparam int SQ_W    = 2 * RAD_IN_W;       // radius squared
    localparam int D2_W    = 34;                 // squared distance
    localparam int A_W     = D2_W + 1;           // d2 + r1^2 - r2^2, signed
    localparam int LIN_W   = DIF_W + A_W;        // d * a, signed
    localparam int F_W     = (SQ_W + 2) + D2_W;  // 4 * r1^2 * d2
    localparam int ROOT_W  = 49;                 // sqrt of the gap in q16
    localparam int RADC_W  = F_W + 32;           // radicand
    localparam int NUM_W   = 70;                 // coordinate numerator
    localparam int Q_W     = 33;                 // coordinate offset bits
    localparam int DV_W    = D2_W + 1;           // 2 * d2
    localparam int LANES   = 4;
    localparam int FRAC_W  = 16;

    localparam logic [1:0] CNT_NONE  = 2'd0;
    localparam logic [1:0] CNT_TOUCH = 2'd1;
    localparam logic [1:0] CNT_CROSS = 2'd2;

    typedef struct packed {
        logic [1:0]       count;
        logic             ident;
        logic [CRD_W-1:0] x1;
        logic [CRD_W-1:0] y1;
        logic [DIF_W-1:0] dx;
        logic [DIF_W-1:0] dy;
        logic [D2_W-1:0]  d2;
        logic [LIN_W-1:0] linx;
        logic [LIN_W-1:0] liny;
    } cci_side_t;

    typedef struct packed {
        logic [1:0]       count;
        logic             ident;
        logic [CRD_W-1:0] x1;
        logic [CRD_W-1:0] y1;
        logic [LANES-1:0] neg;
    } cci_post_t;

endpackage

// ----- src/cci_front.sv -----
// front pipeline: distance, power terms and the exact point count decision
module cci_front
    import cci_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [CRD_W-1:0]    in_x1,
    input  logic [CRD_W-1:0]    in_y1,
    input  logic [RAD_IN_W-1:0] in_r1,
    input  logic [CRD_W-1:0]    in_x2,
    input  logic [CRD_W-1:0]    in_y2,
    input  logic [RAD_IN_W-1:0] in_r2,
    output logic                out_valid,
    output cci_side_t           side,
    output logic [F_W-1:0]      gap
);

    logic [7:0] vld_reg;

    // stage 1
    logic [CRD_W-1:0]    x1_1_reg, y1_1_reg, x2_1_reg, y2_1_reg;
    logic [RAD_IN_W-1:0] r1_1_reg, r2_1_reg;
    // stage 2
    logic [CRD_W-1:0]        x1_2_reg, y1_2_reg;
    logic signed [DIF_W-1:0] dx_2_reg, dy_2_reg;
    logic [SQ_W-1:0]         r1s_2_reg, r2s_2_reg;
    logic                    id_2_reg;
    // stage 3
    logic [CRD_W-1:0]        x1_3_reg, y1_3_reg;
    logic signed [DIF_W-1:0] dx_3_reg, dy_3_reg;
    logic [SQ_W-1:0]         r1s_3_reg, r2s_3_reg;
    logic                    id_3_reg;
    logic [D2_W-1:0]         dxx_3_reg, dyy_3_reg;
    logic signed [2*DIF_W-1:0] dxx_next, dyy_next;
    // stage 4
    logic [CRD_W-1:0]        x1_4_reg, y1_4_reg;
    logic signed [DIF_W-1:0] dx_4_reg, dy_4_reg;
    logic                    id_4_reg;
    logic [D2_W-1:0]         d2_4_reg;
    logic signed [SQ_W:0]    rd_4_reg;
    logic [SQ_W+1:0]         f4r_4_reg;
    // stage 5
    logic [CRD_W-1:0]        x1_5_reg, y1_5_reg;
    logic signed [DIF_W-1:0] dx_5_reg, dy_5_reg;
    logic                    id_5_reg, d2z_5_reg;
    logic [D2_W-1:0]         d2_5_reg;
    logic signed [A_W-1:0]   a_5_reg;
    logic [SQ_W+1:0]         f4r_5_reg;
    // stage 6
    logic [CRD_W-1:0]        x1_6_reg, y1_6_reg;
    logic signed [DIF_W-1:0] dx_6_reg, dy_6_reg;
    logic                    id_6_reg, d2z_6_reg;
    logic [D2_W-1:0]         d2_6_reg;
    logic signed [A_W-1:0]   a_6_reg;
    logic [A_W-2:0]          am_6_reg;
    logic [SQ_W+1:0]         f4r_6_reg;
    // stage 7
    logic [CRD_W-1:0]        x1_7_reg, y1_7_reg;
    logic signed [DIF_W-1:0] dx_7_reg, dy_7_reg;
    logic                    id_7_reg, d2z_7_reg;
    logic [D2_W-1:0]         d2_7_reg;
    logic [2*(A_W-1)-1:0]    a2_7_reg;
    logic [F_W-1:0]          f_7_reg;
    logic signed [LIN_W-1:0] linx_7_reg, liny_7_reg;
    // stage 8
    cci_side_t               side_8_reg;
    logic [F_W-1:0]          gap_8_reg;
    logic [1:0]              cnt_next;
    logic                    over, same;

    assign dxx_next = dx_2_reg * dx_2_reg;
    assign dyy_next = dy_2_reg * dy_2_reg;

    // exact decision on the squared terms
    assign over = a2_7_reg > {2'b00, f_7_reg};
    assign same = a2_7_reg == {2'b00, f_7_reg};

    always_comb
    begin
        if (d2z_7_reg || over)
        begin
            cnt_next = CNT_NONE;
        end
        else if (same)
        begin
            cnt_next = CNT_TOUCH;
        end
        else
        begin
            cnt_next = CNT_CROSS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_1_reg <= in_x1;
            y1_1_reg <= in_y1;
            x2_1_reg <= in_x2;
            y2_1_reg <= in_y2;
            r1_1_reg <= in_r1;
            r2_1_reg <= in_r2;

            x1_2_reg  <= x1_1_reg;
            y1_2_reg  <= y1_1_reg;
            dx_2_reg  <= $signed({x2_1_reg[CRD_W-1], x2_1_reg})
                         - $signed({x1_1_reg[CRD_W-1], x1_1_reg});
            dy_2_reg  <= $signed({y2_1_reg[CRD_W-1], y2_1_reg})
                         - $signed({y1_1_reg[CRD_W-1], y1_1_reg});
            r1s_2_reg <= {{RAD_IN_W{1'b0}}, r1_1_reg} * {{RAD_IN_W{1'b0}}, r1_1_reg};
            r2s_2_reg <= {{RAD_IN_W{1'b0}}, r2_1_reg} * {{RAD_IN_W{1'b0}}, r2_1_reg};
            id_2_reg  <= r1_1_reg == r2_1_reg;

            x1_3_reg  <= x1_2_reg;
            y1_3_reg  <= y1_2_reg;
            dx_3_reg  <= dx_2_reg;
            dy_3_reg  <= dy_2_reg;
            r1s_3_reg <= r1s_2_reg;
            r2s_3_reg <= r2s_2_reg;
            id_3_reg  <= id_2_reg;
            dxx_3_reg <= dxx_next;
            dyy_3_reg <= dyy_next;

            x1_4_reg  <= x1_3_reg;
            y1_4_reg  <= y1_3_reg;
            dx_4_reg  <= dx_3_reg;
            dy_4_reg  <= dy_3_reg;
            id_4_reg  <= id_3_reg;
            d2_4_reg  <= dxx_3_reg + dyy_3_reg;
            rd_4_reg  <= $signed({1'b0, r1s_3_reg}) - $signed({1'b0, r2s_3_reg});
            f4r_4_reg <= {r1s_3_reg, 2'b00};

            x1_5_reg  <= x1_4_reg;
            y1_5_reg  <= y1_4_reg;
            dx_5_reg  <= dx_4_reg;
            dy_5_reg  <= dy_4_reg;
            id_5_reg  <= id_4_reg;
            d2_5_reg  <= d2_4_reg;
            d2z_5_reg <= d2_4_reg == '0;
            a_5_reg   <= $signed({1'b0, d2_4_reg}) + rd_4_reg;
            f4r_5_reg <= f4r_4_reg;

            x1_6_reg  <= x1_5_reg;
            y1_6_reg  <= y1_5_reg;
            dx_6_reg  <= dx_5_reg;
            dy_6_reg  <= dy_5_reg;
            id_6_reg  <= id_5_reg;
            d2z_6_reg <= d2z_5_reg;
            d2_6_reg  <= d2_5_reg;
            a_6_reg   <= a_5_reg;
            am_6_reg  <= a_5_reg[A_W-1] ? (A_W-1)'(-a_5_reg) : a_5_reg[A_W-2:0];
            f4r_6_reg <= f4r_5_reg;

            x1_7_reg   <= x1_6_reg;
            y1_7_reg   <= y1_6_reg;
            dx_7_reg   <= dx_6_reg;
            dy_7_reg   <= dy_6_reg;
            id_7_reg   <= id_6_reg;
            d2z_7_reg  <= d2z_6_reg;
            d2_7_reg   <= d2_6_reg;
            a2_7_reg   <= {{(A_W-1){1'b0}}, am_6_reg} * {{(A_W-1){1'b0}}, am_6_reg};
            f_7_reg    <= {{D2_W{1'b0}}, f4r_6_reg} * {{(SQ_W+2){1'b0}}, d2_6_reg};
            linx_7_reg <= dx_6_reg * a_6_reg;
            liny_7_reg <= dy_6_reg * a_6_reg;

            side_8_reg.count <= cnt_next;
            side_8_reg.ident <= d2z_7_reg && id_7_reg;
            side_8_reg.x1    <= x1_7_reg;
            side_8_reg.y1    <= y1_7_reg;
            side_8_reg.dx    <= dx_7_reg;
            side_8_reg.dy    <= dy_7_reg;
            side_8_reg.d2    <= d2_7_reg;
            side_8_reg.linx  <= linx_7_reg;
            side_8_reg.liny  <= liny_7_reg;
            gap_8_reg        <= f_7_reg - a2_7_reg[F_W-1:0];
        end
    end

    assign out_valid = vld_reg[7];
    assign side      = side_8_reg;
    assign gap       = gap_8_reg;

endmodule

// ----- src/cci_sqrt.sv -----
// pipelined integer square root, one root bit per stage, sideband carried alongside
module cci_sqrt
    import cci_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cci_side_t         side_in,
    input  logic [F_W-1:0]    gap_in,
    output logic              out_valid,
    output cci_side_t         side_out,
    output logic [ROOT_W-1:0] root_out
);

    localparam int REM_W = ROOT_W + 2;

    logic [RADC_W-1:0] rad_reg  [1:ROOT_W];
    logic [ROOT_W-1:0] root_reg [1:ROOT_W];
    logic [REM_W-1:0]  rem_reg  [1:ROOT_W];
    cci_side_t         side_reg [1:ROOT_W];
    logic [ROOT_W:1]   vld_reg;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [RADC_W-1:0] rad_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [REM_W-1:0]  rem_cur;
        cci_side_t         side_cur;
        logic              vld_cur;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            // radicand is the gap scaled by 2^32 so the root comes out in q16
            assign rad_cur  = {gap_in, 32'h0};
            assign root_cur = '0;
            assign rem_cur  = '0;
            assign side_cur = side_in;
            assign vld_cur  = in_valid;
        end
        else
        begin : g_next
            assign rad_cur  = rad_reg[k];
            assign root_cur = root_reg[k];
            assign rem_cur  = rem_reg[k];
            assign side_cur = side_reg[k];
            assign vld_cur  = vld_reg[k];
        end

        assign rem_sh = {rem_cur[REM_W-3:0], rad_cur[RADC_W-1 -: 2]};
        assign trial  = {root_cur, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k+1]  <= rad_cur << 2;
                root_reg[k+1] <= {root_cur[ROOT_W-2:0], ge};
                rem_reg[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
                side_reg[k+1] <= side_cur;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_cur;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign side_out  = side_reg[ROOT_W];
    assign root_out  = root_reg[ROOT_W];

endmodule

// ----- src/cci_numer.sv -----
// builds the four signed numerators and the divisor for the point coordinates
module cci_numer
    import cci_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  cci_side_t                   side_in,
    input  logic [ROOT_W-1:0]           root_in,
    output logic                        out_valid,
    output cci_post_t                   post,
    output logic [LANES-1:0][NUM_W-1:0] num,
    output logic [DV_W-1:0]             dv
);

    localparam int TS_W = DIF_W + ROOT_W + 1;

    logic [2:0] vld_reg;

    // stage 1: perpendicular products
    cci_side_t               side_1_reg;
    logic signed [TS_W-1:0]  tsx_1_reg, tsy_1_reg;
    // stage 2: signed numerators
    cci_side_t               side_2_reg;
    logic [LANES-1:0][NUM_W-1:0] n_2_reg;
    logic [NUM_W-1:0]        linx_ext, liny_ext, tsx_ext, tsy_ext;
    // stage 3: magnitudes plus half divisor for rounding
    cci_post_t               post_3_reg;
    logic [LANES-1:0][NUM_W-1:0] num_3_reg;
    logic [DV_W-1:0]         dv_3_reg;
    logic [NUM_W-1:0]        d2_ext;

    assign linx_ext = {{(NUM_W-LIN_W-FRAC_W){side_1_reg.linx[LIN_W-1]}},
                       side_1_reg.linx, {FRAC_W{1'b0}}};
    assign liny_ext = {{(NUM_W-LIN_W-FRAC_W){side_1_reg.liny[LIN_W-1]}},
                       side_1_reg.liny, {FRAC_W{1'b0}}};
    assign tsx_ext  = {{(NUM_W-TS_W){tsx_1_reg[TS_W-1]}}, tsx_1_reg};
    assign tsy_ext  = {{(NUM_W-TS_W){tsy_1_reg[TS_W-1]}}, tsy_1_reg};
    assign d2_ext   = {{(NUM_W-D2_W){1'b0}}, side_2_reg.d2};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_1_reg <= side_in;
            tsx_1_reg  <= $signed(side_in.dx) * $signed({1'b0, root_in});
            tsy_1_reg  <= $signed(side_in.dy) * $signed({1'b0, root_in});

            side_2_reg <= side_1_reg;
            // lanes: p-h x, p-h y, p+h x, p+h y
            n_2_reg[0] <= linx_ext + tsy_ext;
            n_2_reg[1] <= liny_ext - tsx_ext;
            n_2_reg[2] <= linx_ext - tsy_ext;
            n_2_reg[3] <= liny_ext + tsx_ext;

            post_3_reg.count <= side_2_reg.count;
            post_3_reg.ident <= side_2_reg.ident;
            post_3_reg.x1    <= side_2_reg.x1;
            post_3_reg.y1    <= side_2_reg.y1;
            for (int i = 0; i < LANES; i++)
            begin
                post_3_reg.neg[i] <= n_2_reg[i][NUM_W-1];
                num_3_reg[i]      <= n_2_reg[i][NUM_W-1] ? (d2_ext - n_2_reg[i])
                                                         : (n_2_reg[i] + d2_ext);
            end
            dv_3_reg <= {side_2_reg.d2, 1'b0};
        end
    end

    assign out_valid = vld_reg[2];
    assign post      = post_3_reg;
    assign num       = num_3_reg;
    assign dv        = dv_3_reg;

endmodule

// ----- src/cci_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module cci_div
    import cci_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DV_W-1:0]  dv,
    output logic [Q_W-1:0]   quo
);

    logic [Q_W-1:0]  lo_reg  [1:Q_W];
    logic [Q_W-1:0]  q_reg   [1:Q_W];
    logic [DV_W-1:0] rem_reg [1:Q_W];
    logic [DV_W-1:0] dv_reg  [1:Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [Q_W-1:0]  lo_cur;
        logic [Q_W-1:0]  q_cur;
        logic [DV_W-1:0] rem_cur;
        logic [DV_W-1:0] dv_cur;
        logic [DV_W:0]   rem_sh;
        logic            ge;

        if (k == 0)
        begin : g_first
            // the offset fits in the quotient width, so the top part is below the divisor
            assign lo_cur  = num[Q_W-1:0];
            assign q_cur   = '0;
            assign rem_cur = num[Q_W+DV_W-1:Q_W];
            assign dv_cur  = dv;
        end
        else
        begin : g_next
            assign lo_cur  = lo_reg[k];
            assign q_cur   = q_reg[k];
            assign rem_cur = rem_reg[k];
            assign dv_cur  = dv_reg[k];
        end

        assign rem_sh = {rem_cur, lo_cur[Q_W-1]};
        assign ge     = rem_sh >= {1'b0, dv_cur};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[k+1]  <= lo_cur << 1;
                q_reg[k+1]   <= {q_cur[Q_W-2:0], ge};
                rem_reg[k+1] <= ge ? DV_W'(rem_sh - {1'b0, dv_cur}) : rem_sh[DV_W-1:0];
                dv_reg[k+1]  <= dv_cur;
            end
        end
    end

    assign quo = q_reg[Q_W];

endmodule

// ----- src/circle_circle_intersection.sv -----
// top level: circle pair stream in, intersection count and points stream out
//
// One circle pair is taken every clock cycle while the pipeline is not held,
// and each pair gives one result transaction after it is accepted, passing in
// order through the exact integer decision, the square root (one root bit per
// stage), the numerators, the four parallel dividers (one quotient bit per
// stage) and the output register. A two-entry output buffer lets the pipeline
// advance one more step while a result waits; the pipeline holds while the
// spare entry is full. Points are signed q16 values; when there is no
// intersection the count and the points read zero, and identical_flag marks
// two coincident circles.
module circle_circle_intersection
    import cci_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_center_x, first_center_y, first_radius,
    // second_center_x, second_center_y, second_radius, zero pad
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // point_count, first_x, first_y, second_x, second_y, identical_flag, zero pad
    output logic [135:0] m_axis_tdata
);

    localparam int OUT_W = 135;

    logic                        en;
    logic                        fr_valid, sq_valid, nm_valid;
    cci_side_t                   fr_side, sq_side;
    logic [F_W-1:0]              fr_gap;
    logic [ROOT_W-1:0]           sq_root;
    cci_post_t                   nm_post;
    logic [LANES-1:0][NUM_W-1:0] nm_num;
    logic [DV_W-1:0]             nm_dv;
    logic [LANES-1:0][Q_W-1:0]   quo;

    cci_post_t                   post_reg [1:Q_W];
    logic [Q_W:1]                pvld_reg;

    logic [Q_W-1:0]              base_x, base_y;
    logic [LANES-1:0][Q_W-1:0]   crd;
    logic [OUT_W-1:0]            res;

    logic                        out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0]            out_data_reg, skid_data_reg;
    logic                        out_take;

    // pipeline moves whenever the spare output entry is free
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    cci_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_x1     (s_axis_tdata[15:0]),
        .in_y1     (s_axis_tdata[31:16]),
        .in_r1     (s_axis_tdata[46:32]),
        .in_x2     (s_axis_tdata[62:47]),
        .in_y2     (s_axis_tdata[78:63]),
        .in_r2     (s_axis_tdata[93:79]),
        .out_valid (fr_valid),
        .side      (fr_side),
        .gap       (fr_gap)
    );

    cci_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .side_in   (fr_side),
        .gap_in    (fr_gap),
        .out_valid (sq_valid),
        .side_out  (sq_side),
        .root_out  (sq_root)
    );

    cci_numer u_numer (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .side_in   (sq_side),
        .root_in   (sq_root),
        .out_valid (nm_valid),
        .post      (nm_post),
        .num       (nm_num),
        .dv        (nm_dv)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        cci_div u_div (
            .clk (clk),
            .en  (en),
            .num (nm_num[l]),
            .dv  (nm_dv),
            .quo (quo[l])
        );
    end

    // sideband follows the dividers
    for (genvar k = 0; k < Q_W; k++)
    begin : g_post
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                post_reg[k+1] <= (k == 0) ? nm_post : post_reg[(k == 0) ? 1 : k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pvld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                pvld_reg[k+1] <= (k == 0) ? nm_valid : pvld_reg[(k == 0) ? 1 : k];
            end
        end
    end

    assign base_x = {post_reg[Q_W].x1[CRD_W-1], post_reg[Q_W].x1, {FRAC_W{1'b0}}};
    assign base_y = {post_reg[Q_W].y1[CRD_W-1], post_reg[Q_W].y1, {FRAC_W{1'b0}}};

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (post_reg[Q_W].count == CNT_NONE)
            begin
                crd[i] = '0;
            end
            else if (post_reg[Q_W].neg[i])
            begin
                crd[i] = (i % 2 == 0) ? (base_x - quo[i]) : (base_y - quo[i]);
            end
            else
            begin
                crd[i] = (i % 2 == 0) ? (base_x + quo[i]) : (base_y + quo[i]);
            end
        end
    end

    assign res = {post_reg[Q_W].ident, crd[3], crd[2], crd[1], crd[0], post_reg[Q_W].count};

    assign out_take = m_axis_tready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pvld_reg[Q_W];
            end
        end
        else if (en && pvld_reg[Q_W])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (en && pvld_reg[Q_W])
        begin
            skid_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("spare output entry full while output register empty");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == CNT_NONE) |-> m_axis_tdata[133:2] == '0)
        else $error("points not cleared for a pair with no intersection");

    a_ident_none: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[134]) |-> m_axis_tdata[1:0] == CNT_NONE)
        else $error("identical circles reported with points");

    a_touch_same: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == CNT_TOUCH)
        |-> (m_axis_tdata[34:2] == m_axis_tdata[100:68]
             && m_axis_tdata[67:35] == m_axis_tdata[133:101]))
        else $error("tangent pair gave two different points");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_take) |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("spare output entry changed while stalled");

endmodule
